// ===== design/button_hold_time_tracker_macros.svh =====
// button_hold_time_tracker_macros.svh: assertion macros used by the tracker engine
// no dependencies; expects clk and rst in the scope of each use
`ifndef BUTTON_HOLD_TIME_TRACKER_MACROS_SVH
`define BUTTON_HOLD_TIME_TRACKER_MACROS_SVH

// same-cycle implication, checked out of reset
`define BHTT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BHTT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bhtt_pkg.sv =====
// bhtt_pkg: types, codes and constants of the button hold time tracker
// no dependencies
`default_nettype none

package bhtt_pkg;

  // field widths
  localparam int BTN_W      = 2;
  localparam int KIND_W     = 2;
  localparam int MS_W       = 32;
  localparam int STEP_W     = 10;
  localparam int MARK_IDX_W = 2;
  localparam int CFG_IDX_W  = 2;

  // default sizes
  localparam int DEF_NUM_BUTTONS = 4;
  localparam int DEF_NUM_MARKS   = 2;

  // register values after reset
  localparam logic [MS_W-1:0]   RST_MARK_FIRST  = 32'd3000;
  localparam logic [MS_W-1:0]   RST_MARK_SECOND = 32'd10000;
  localparam logic [STEP_W-1:0] RST_POLL_STEP   = 10'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MARK_FIRST  = 2'd0,
    REG_MARK_SECOND = 2'd1,
    REG_POLL_STEP   = 2'd2
  } reg_index_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DOWN = 2'd0,
    KIND_HOLD = 2'd1,
    KIND_UP   = 2'd2
  } evt_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } bhtt_state_t;

  // live configuration handed to the engine
  typedef struct packed {
    logic [MS_W-1:0]   mark_first;
    logic [MS_W-1:0]   mark_second;
    logic [STEP_W-1:0] poll_step;
  } cfg_t;

  // one button's entry in the state memory
  typedef struct packed {
    logic                  pressed;
    logic [MS_W-1:0]       held;
    logic [MARK_IDX_W-1:0] mark;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== design/bhtt_if.sv =====
// bhtt_tick_if, bhtt_evt_if: valid/ready channels for poll ticks and events
// depends on bhtt_pkg
`default_nettype none

interface bhtt_tick_if import bhtt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] button_index;
  logic             key_low;

  modport source (output valid, output button_index, output key_low, input ready);
  modport sink   (input valid, input button_index, input key_low, output ready);
endinterface

interface bhtt_evt_if import bhtt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [BTN_W-1:0]  event_button;
  logic [MS_W-1:0]   event_ms;
  logic              last_of_run;

  modport source (
    output valid, output event_kind, output event_button, output event_ms,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input event_kind, input event_button, input event_ms,
    input last_of_run, output ready
  );
endinterface

`default_nettype wire

// ===== design/bhtt_ram.sv =====
// bhtt_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module bhtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [AW-1:0]        raddr,
  output      logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/bhtt_engine.sv =====
// bhtt_engine: per-button read-modify-write sequencer and event output register
// depends on bhtt_pkg, bhtt_if, bhtt_ram and the tracker macro header
`default_nettype none

`include "button_hold_time_tracker_macros.svh"

module bhtt_engine import bhtt_pkg::*; #(
  parameter int NUM_BUTTONS = DEF_NUM_BUTTONS,
  parameter int NUM_MARKS   = DEF_NUM_MARKS
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  bhtt_tick_if.sink  tick,
  bhtt_evt_if.source evt
);
  localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam logic [6:0]            BTN_LIMIT = 7'(NUM_BUTTONS);
  localparam logic [MARK_IDX_W-1:0] MARK_LIMIT = MARK_IDX_W'(NUM_MARKS);

  bhtt_state_t state, state_next;

  // item registers
  logic [BTN_W-1:0]      btn_r;
  logic [AW-1:0]         addr_r;
  logic                  key_r;
  logic                  pressed_r;
  logic [MS_W-1:0]       held_r;
  logic [MARK_IDX_W-1:0] mark_r;
  logic                  down_pend;
  logic                  up_pend;

  // entry valid bits, cleared by reset
  logic [NUM_BUTTONS-1:0] valid;

  // output register
  logic              ev_valid;
  logic [KIND_W-1:0] ev_kind;
  logic [BTN_W-1:0]  ev_btn;
  logic [MS_W-1:0]   ev_ms;
  logic              ev_last;

  logic                  accept, in_range;
  logic                  ram_we;
  logic [ENTRY_W-1:0]    ram_rdata;
  entry_t                entry_rd, entry_wr;
  logic [MS_W-1:0]       base;
  logic [MS_W:0]         sum;
  logic [MS_W-1:0]       held_sat;
  logic [MARK_IDX_W-1:0] mark_nx;
  logic [MS_W-1:0]       mark_val_now, mark_val_then;
  logic                  hold_now, hold_then;
  logic                  any_pend, out_free, ev_go;
  evt_kind_t             go_kind;
  logic [MS_W-1:0]       go_ms;
  logic                  go_last;

  // state memory
  assign entry_wr = '{pressed: pressed_r, held: held_r, mark: mark_r};

  bhtt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BUTTONS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (entry_wr),
    .re    (accept),
    .raddr (AW'(tick.button_index)),
    .rdata (ram_rdata)
  );

  // entry never written reads as released
  assign entry_rd = valid[addr_r] ? entry_t'(ram_rdata) : '0;

  // saturating held time update
  assign base     = entry_rd.pressed ? entry_rd.held : '0;
  assign sum      = {1'b0, base} + (MS_W+1)'(cfg.poll_step);
  assign held_sat = sum[MS_W] ? '1 : sum[MS_W-1:0];

  // hold mark checks for the current and the following mark
  assign mark_nx       = mark_r + 1'b1;
  assign mark_val_now  = (mark_r == '0) ? cfg.mark_first : cfg.mark_second;
  assign mark_val_then = (mark_nx == '0) ? cfg.mark_first : cfg.mark_second;
  assign hold_now      = pressed_r && (mark_r < MARK_LIMIT) && (held_r >= mark_val_now);
  assign hold_then     = pressed_r && (mark_nx < MARK_LIMIT) && (held_r >= mark_val_then);

  assign any_pend = down_pend || hold_now || up_pend;
  assign out_free = !ev_valid || evt.ready;
  assign ev_go    = (state == S_EMIT) && any_pend && out_free;
  assign ram_we   = (state == S_EMIT) && !any_pend;

  assign tick.ready = (state == S_IDLE);
  assign accept     = tick.valid && tick.ready;
  assign in_range   = {5'd0, tick.button_index} < BTN_LIMIT;

  // next event word: down, then holds in mark order, then up
  always_comb begin
    go_kind = KIND_UP;
    go_ms   = held_r;
    go_last = 1'b1;
    if (down_pend) begin
      go_kind = KIND_DOWN;
      go_ms   = '0;
      go_last = !hold_now;
    end else if (hold_now) begin
      go_kind = KIND_HOLD;
      go_ms   = mark_val_now;
      go_last = !hold_then;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && in_range) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (key_r || entry_rd.pressed) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!any_pend) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      btn_r  <= tick.button_index;
      addr_r <= AW'(tick.button_index);
      key_r  <= tick.key_low;
    end
    if (state == S_READ) begin
      if (key_r) begin
        pressed_r <= 1'b1;
        held_r    <= held_sat;
        mark_r    <= entry_rd.pressed ? entry_rd.mark : '0;
      end else begin
        pressed_r <= 1'b0;
        held_r    <= entry_rd.held;
        mark_r    <= entry_rd.mark;
      end
    end else if (ev_go && !down_pend && hold_now) begin
      mark_r <= mark_nx;
    end
  end

  // pending event flags
  always_ff @(posedge clk) begin
    if (rst) begin
      down_pend <= 1'b0;
      up_pend   <= 1'b0;
    end else if (state == S_READ) begin
      down_pend <= key_r && !entry_rd.pressed;
      up_pend   <= !key_r && entry_rd.pressed;
    end else if (ev_go) begin
      if (down_pend) begin
        down_pend <= 1'b0;
      end else if (!hold_now) begin
        up_pend <= 1'b0;
      end
    end
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ram_we) begin
      valid[addr_r] <= 1'b1;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (ev_go) begin
      ev_valid <= 1'b1;
    end else if (evt.ready) begin
      ev_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_go) begin
      ev_kind <= go_kind;
      ev_btn  <= btn_r;
      ev_ms   <= go_ms;
      ev_last <= go_last;
    end
  end

  assign evt.valid        = ev_valid;
  assign evt.event_kind   = ev_kind;
  assign evt.event_button = ev_btn;
  assign evt.event_ms     = ev_ms;
  assign evt.last_of_run  = ev_last;

  // checks
  `BHTT_ASSERT_IMP(a_pend_excl, 1'b1, !(down_pend && up_pend), "down and up both pending")
  `BHTT_ASSERT_IMP(a_idle_clean, state == S_IDLE, !down_pend && !up_pend, "pending word in idle")
  `BHTT_ASSERT_IMP(a_hold_pressed, hold_now, pressed_r && !up_pend, "hold on released button")
  `BHTT_ASSERT_NXT(a_wb_idle, ram_we, state == S_IDLE && !ev_go, "write back not ending item")
  `BHTT_ASSERT_NXT(a_take_read, accept && in_range, state == S_READ, "accepted tick not read")

endmodule

`default_nettype wire

// ===== design/button_hold_time_tracker.sv =====
// Button hold time tracker: per-button press, hold mark and release events.
// An in-range tick reads its button's entry in the cycle after acceptance (S_READ); S_EMIT
// then registers its event words on evt, one word per cycle while the output register is free.
// An item ends with the entry write-back, or after the read for a release on a released button;
// new ticks wait until it ends. It uses the state memory read, write-back and one output register.
// Reset: config to 3000/10000/10 ms, all buttons released at once via valid bits.
// depends on bhtt_pkg, bhtt_if, bhtt_engine
`default_nettype none

module button_hold_time_tracker import bhtt_pkg::*; #(
  parameter int NUM_BUTTONS = DEF_NUM_BUTTONS,
  parameter int NUM_MARKS   = DEF_NUM_MARKS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MS_W-1:0]      cfg_data,
  bhtt_tick_if.sink                 tick,
  bhtt_evt_if.source                evt
);

  cfg_t cfg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mark_first  <= RST_MARK_FIRST;
      cfg.mark_second <= RST_MARK_SECOND;
      cfg.poll_step   <= RST_POLL_STEP;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_MARK_FIRST:  cfg.mark_first  <= cfg_data;
        REG_MARK_SECOND: cfg.mark_second <= cfg_data;
        REG_POLL_STEP:   cfg.poll_step   <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  bhtt_engine #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .NUM_MARKS   (NUM_MARKS)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .tick (tick),
    .evt  (evt)
  );

endmodule

`default_nettype wire
